@@ rtl/file_suffix_policy_classifier_unit_assert.svh @@
// Assertion macros used by the checker file of the suffix classifier.
`ifndef FILE_SUFFIX_POLICY_CLASSIFIER_UNIT_ASSERT_SVH
`define FILE_SUFFIX_POLICY_CLASSIFIER_UNIT_ASSERT_SVH

// Clocked assertion, muted while reset is held
`define FSPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define FSPC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/fspc_pkg.sv @@
// ----------------------------------------------------------------------------
// fspc_pkg
// Types, codes and the suffix table of the file suffix policy classifier.
// ----------------------------------------------------------------------------
package fspc_pkg;

    // Default number of name bytes held in the window
    localparam int WINDOW_CHARS_DEFAULT = 8;

    // Longest suffix in the table, in bytes
    localparam int MATCH_CHARS = 8;

    localparam int SUFFIX_COUNT = 61;

    // Policy register
    localparam logic [1:0] POLICY_PARANOID = 2'd2;
    localparam logic [1:0] POLICY_RESET    = 2'd1;

    // ASCII bytes the datapath looks at
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [2:0] {
        VERDICT_KEEP        = 3'd0,
        VERDICT_PARANOID    = 3'd1,
        VERDICT_JAVASCRIPT  = 3'd2,
        VERDICT_BINARY      = 3'd3,
        VERDICT_SCRIPT      = 3'd4,
        VERDICT_ARCHIVE     = 3'd5,
        VERDICT_NOT_ALLOWED = 3'd6
    } t_verdict;

    // Suffix groups, in check order
    typedef enum logic [2:0] {
        GRP_PARANOID = 3'd0,
        GRP_JS       = 3'd1,
        GRP_BINARY   = 3'd2,
        GRP_SCRIPT   = 3'd3,
        GRP_ARCHIVE  = 3'd4,
        GRP_ALLOW    = 3'd5
    } t_group;

    localparam int GROUP_COUNT = 6;

    // Suffix text right-aligned: last character in bits [7:0], unused bytes zero
    typedef struct packed {
        logic [8*MATCH_CHARS-1:0] text;
        t_group                   group;
    } t_suffix;

    localparam t_suffix SUFFIX_TABLE [SUFFIX_COUNT] = '{
        '{64'(".svg"),     GRP_PARANOID}, '{64'(".ttf"),   GRP_PARANOID},
        '{64'(".otf"),     GRP_PARANOID}, '{64'(".woff"),  GRP_PARANOID},
        '{64'(".woff2"),   GRP_PARANOID}, '{64'(".mp3"),   GRP_PARANOID},
        '{64'(".mp4"),     GRP_PARANOID}, '{64'(".m4a"),   GRP_PARANOID},
        '{64'(".webm"),    GRP_PARANOID}, '{64'(".ogg"),   GRP_PARANOID},
        '{64'(".oga"),     GRP_PARANOID}, '{64'(".ogv"),   GRP_PARANOID},
        '{64'(".js"),      GRP_JS},       '{64'(".mjs"),   GRP_JS},
        '{64'(".exe"),     GRP_BINARY},   '{64'(".dll"),   GRP_BINARY},
        '{64'(".dylib"),   GRP_BINARY},   '{64'(".so"),    GRP_BINARY},
        '{64'(".jar"),     GRP_BINARY},   '{64'(".class"), GRP_BINARY},
        '{64'(".sh"),      GRP_SCRIPT},   '{64'(".bat"),   GRP_SCRIPT},
        '{64'(".cmd"),     GRP_SCRIPT},   '{64'(".ps1"),   GRP_SCRIPT},
        '{64'(".php"),     GRP_SCRIPT},   '{64'(".pl"),    GRP_SCRIPT},
        '{64'(".py"),      GRP_SCRIPT},   '{64'(".rb"),    GRP_SCRIPT},
        '{64'(".zip"),     GRP_ARCHIVE},  '{64'(".rar"),   GRP_ARCHIVE},
        '{64'(".7z"),      GRP_ARCHIVE},  '{64'(".tar"),   GRP_ARCHIVE},
        '{64'(".gz"),      GRP_ARCHIVE},
        '{64'("mimetype"), GRP_ALLOW},    '{64'(".xml"),   GRP_ALLOW},
        '{64'(".opf"),     GRP_ALLOW},    '{64'(".ncx"),   GRP_ALLOW},
        '{64'(".xhtml"),   GRP_ALLOW},    '{64'(".html"),  GRP_ALLOW},
        '{64'(".htm"),     GRP_ALLOW},    '{64'(".css"),   GRP_ALLOW},
        '{64'(".svg"),     GRP_ALLOW},    '{64'(".png"),   GRP_ALLOW},
        '{64'(".jpg"),     GRP_ALLOW},    '{64'(".jpeg"),  GRP_ALLOW},
        '{64'(".gif"),     GRP_ALLOW},    '{64'(".webp"),  GRP_ALLOW},
        '{64'(".avif"),    GRP_ALLOW},    '{64'(".ttf"),   GRP_ALLOW},
        '{64'(".otf"),     GRP_ALLOW},    '{64'(".woff"),  GRP_ALLOW},
        '{64'(".woff2"),   GRP_ALLOW},    '{64'(".txt"),   GRP_ALLOW},
        '{64'(".xpgt"),    GRP_ALLOW},    '{64'(".mp3"),   GRP_ALLOW},
        '{64'(".mp4"),     GRP_ALLOW},    '{64'(".m4a"),   GRP_ALLOW},
        '{64'(".webm"),    GRP_ALLOW},    '{64'(".ogg"),   GRP_ALLOW},
        '{64'(".oga"),     GRP_ALLOW},    '{64'(".ogv"),   GRP_ALLOW}
    };

    // A suffix matches when every used byte was seen and equals the window byte.
    // win: newest byte in [7:0]; seen[j]: byte j of the window holds a name byte.
    function automatic logic suffix_match(
        input logic [8*MATCH_CHARS-1:0] win,
        input logic [MATCH_CHARS-1:0]   seen,
        input logic [8*MATCH_CHARS-1:0] sfx
    );
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < MATCH_CHARS; j++) begin
            if (sfx[8*j +: 8] != 8'h00) begin
                if (!seen[j] || (win[8*j +: 8] != sfx[8*j +: 8])) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

@@ rtl/file_suffix_policy_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// file_suffix_policy_classifier_unit
// Classifies a streamed file name by its suffix and gives one verdict per name.
// ----------------------------------------------------------------------------
// Throughput: one name byte per cycle while the result side takes verdicts.
// A verdict follows the transfer of the final byte (or of an empty-name
//   marker): that transfer loads the compare register, and the result
//   register then loads through the suffix comparators once it is free.
// Reset (synchronous, active low): window and count cleared, no result
//   pending, policy set to POLICY_RESET (code 1, not paranoid).
module file_suffix_policy_classifier_unit #(
    parameter int WINDOW_CHARS = fspc_pkg::WINDOW_CHARS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // name byte stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] name_char
    input  logic       s_axis_tlast,   // last_char
    input  logic       s_axis_tuser,   // [0] empty_name
    // verdict stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [2:0] verdict, [7:3] zero
    // policy register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    localparam int CountW = $clog2(WINDOW_CHARS + 1);
    localparam int MatchW = fspc_pkg::MATCH_CHARS;

    logic [7:0]        r_window [WINDOW_CHARS];
    logic [7:0]        n_window [WINDOW_CHARS];
    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic [1:0]        r_policy;

    logic                r_eval_valid;
    logic [8*MatchW-1:0] r_eval_win;
    logic [MatchW-1:0]   r_eval_seen;
    logic [8*MatchW-1:0] n_eval_win;
    logic [MatchW-1:0]   n_eval_seen;

    logic                 r_out_valid;
    fspc_pkg::t_verdict   r_out_verdict;
    fspc_pkg::t_verdict   w_verdict;

    logic [7:0]              w_char;
    logic                    w_in_xfer;
    logic                    w_end_name;
    logic                    w_eval_adv;
    logic [fspc_pkg::GROUP_COUNT-1:0] w_hit;
    logic                    w_slash;

    // Handshakes
    assign w_in_xfer     = s_axis_tvalid & s_axis_tready;
    assign w_end_name    = s_axis_tuser | s_axis_tlast;
    assign w_eval_adv    = r_eval_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_eval_valid | ~r_out_valid | m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // ASCII lower-casing of the incoming byte
    always_comb begin
        w_char = s_axis_tdata;
        if ((s_axis_tdata >= fspc_pkg::CHAR_UPPER_A) &&
            (s_axis_tdata <= fspc_pkg::CHAR_UPPER_Z)) begin
            w_char = s_axis_tdata + fspc_pkg::CASE_OFFSET;
        end
    end

    // Window shifted by one byte, saturating count
    always_comb begin
        n_window[0] = w_char;
        for (int k = 1; k < WINDOW_CHARS; k++) begin
            n_window[k] = r_window[k-1];
        end
        if (r_count == CountW'(WINDOW_CHARS)) begin
            n_count = r_count;
        end else begin
            n_count = r_count + 1'b1;
        end
    end

    // Snapshot of the newest bytes for the compare stage
    always_comb begin
        for (int j = 0; j < MatchW; j++) begin
            n_eval_win[8*j +: 8] = n_window[j];
            n_eval_seen[j]       = CountW'(j) < n_count;
        end
        if (s_axis_tuser) begin
            n_eval_win  = '0;
            n_eval_seen = '0;
        end
    end

    // Name window and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_CHARS; k++) begin
                r_window[k] <= '0;
            end
            r_count <= '0;
        end else if (w_in_xfer) begin
            if (w_end_name) begin
                for (int k = 0; k < WINDOW_CHARS; k++) begin
                    r_window[k] <= '0;
                end
                r_count <= '0;
            end else begin
                r_window <= n_window;
                r_count  <= n_count;
            end
        end
    end

    // Policy register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= fspc_pkg::POLICY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_policy <= i_cfg_data;
        end
    end

    // Compare stage input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_valid <= 1'b0;
        end else if (w_in_xfer && w_end_name) begin
            r_eval_valid <= 1'b1;
        end else if (w_eval_adv) begin
            r_eval_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_end_name) begin
            r_eval_win  <= n_eval_win;
            r_eval_seen <= n_eval_seen;
        end
    end

    // Parallel suffix comparators, OR-ed per group
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < fspc_pkg::SUFFIX_COUNT; i++) begin
            if (fspc_pkg::suffix_match(r_eval_win, r_eval_seen,
                                       fspc_pkg::SUFFIX_TABLE[i].text)) begin
                w_hit[fspc_pkg::SUFFIX_TABLE[i].group] = 1'b1;
            end
        end
    end

    assign w_slash = r_eval_seen[0] & (r_eval_win[7:0] == fspc_pkg::CHAR_SLASH);

    // Verdict priority
    always_comb begin
        if (w_slash) begin
            w_verdict = fspc_pkg::VERDICT_KEEP;
        end else if ((r_policy == fspc_pkg::POLICY_PARANOID) &&
                     w_hit[fspc_pkg::GRP_PARANOID]) begin
            w_verdict = fspc_pkg::VERDICT_PARANOID;
        end else if (w_hit[fspc_pkg::GRP_JS]) begin
            w_verdict = fspc_pkg::VERDICT_JAVASCRIPT;
        end else if (w_hit[fspc_pkg::GRP_BINARY]) begin
            w_verdict = fspc_pkg::VERDICT_BINARY;
        end else if (w_hit[fspc_pkg::GRP_SCRIPT]) begin
            w_verdict = fspc_pkg::VERDICT_SCRIPT;
        end else if (w_hit[fspc_pkg::GRP_ARCHIVE]) begin
            w_verdict = fspc_pkg::VERDICT_ARCHIVE;
        end else if (w_hit[fspc_pkg::GRP_ALLOW]) begin
            w_verdict = fspc_pkg::VERDICT_KEEP;
        end else begin
            w_verdict = fspc_pkg::VERDICT_NOT_ALLOWED;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_eval_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_eval_adv) begin
            r_out_verdict <= w_verdict;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_verdict};

endmodule

@@ rtl/fspc_checker.sv @@
// ----------------------------------------------------------------------------
// fspc_checker
// Port-level checks on the verdict stream of the suffix classifier.
// ----------------------------------------------------------------------------
`include "file_suffix_policy_classifier_unit_assert.svh"

module fspc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // A stalled verdict stays put until its transfer
    `FSPC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "verdict dropped or changed while stalled")

    // Only defined verdict codes, upper bits zero
    `FSPC_ASSERT(a_out_code, m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0) && (m_axis_tdata[2:0] != 3'd7), "undefined verdict code")

    // Nothing pending right after reset
    `FSPC_ASSERT_ALWAYS(a_out_reset, !i_rst_n |=> !m_axis_tvalid, "verdict valid after reset")

endmodule

bind file_suffix_policy_classifier_unit fspc_checker u_fspc_checker (.*);
